// File: rtl/asfc_pkg.sv
// Shared types, constants and helper functions of the audio sample format converter.
package asfc_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int CHAN_W       = 3;
  localparam int MAX_CHANNELS = 2 ** CHAN_W;
  localparam int WORD_W       = 64;
  localparam int BYTES_W      = 4;

  // Queue between the front and the back part, and the result queue.
  localparam int MID_DEPTH  = 2;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NR_ON   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FMT = 1'b1;

  // 1.0 in Q2.30.
  localparam logic signed [SAMPLE_W:0] Q_ONE = 33'sd1073741824;

  typedef enum logic [2:0] {
    FMT_F32 = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_S24 = 3'd3,
    FMT_F64 = 3'd4,
    FMT_S64 = 3'd5,
    FMT_U8  = 3'd6,
    FMT_S8  = 3'd7
  } asfc_fmt_t;

  localparam asfc_fmt_t FMT_RESET = FMT_S16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          channel;
    logic                       block_end;
  } asfc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  out_word;
    logic [BYTES_W-1:0] out_bytes;
    logic               block_end_out;
  } asfc_out_t;

  // Sample after smoothing, tagged with the format it is to be converted to.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    asfc_fmt_t                  fmt;
    logic                       block_end;
  } asfc_mid_t;

  // Status of the queue between the two parts.
  typedef struct packed {
    logic full;
    logic empty;
  } asfc_qstat_t;

  // Full-scale factor of the integer formats that go through the multiplier.
  function automatic logic [30:0] scale_of(input asfc_fmt_t fmt);
    logic [30:0] k;
    k = '0;
    unique case (fmt)
      FMT_S16:         k = 31'd32767;
      FMT_S32:         k = 31'd2147483647;
      FMT_S24:         k = 31'd8388607;
      FMT_U8, FMT_S8:  k = 31'd127;
      default:         k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [BYTES_W-1:0] bytes_of(input asfc_fmt_t fmt);
    logic [BYTES_W-1:0] n;
    n = 4'd1;
    unique case (fmt)
      FMT_F32, FMT_S32: n = 4'd4;
      FMT_S16:          n = 4'd2;
      FMT_S24:          n = 4'd3;
      FMT_F64, FMT_S64: n = 4'd8;
      default:          n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/asfc_front.sv
// Front part: accepts samples and applies the per-channel smoothing with clamp.
module asfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 nr_on,
  input  asfc_pkg::asfc_fmt_t  fmt,
  input  logic                 in_push,
  input  asfc_pkg::asfc_in_t   in_item,
  input  asfc_pkg::asfc_qstat_t q_stat,
  output logic                 q_push,
  output asfc_pkg::asfc_mid_t  q_item
);
  import asfc_pkg::*;

  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] prev_r;
  logic [CHAN_W-1:0]                     slot;
  logic signed [SAMPLE_W-1:0]            half;
  logic signed [SAMPLE_W-1:0]            prev;
  logic signed [SAMPLE_W:0]              sum;
  logic signed [SAMPLE_W:0]              clamped;

  assign q_push = in_push && !q_stat.full;
  assign slot   = in_item.channel;

  // Halving is floor(sample / 2); the stored value is this half, not the clamped sum.
  assign half = in_item.sample_in >>> 1;
  assign prev = $signed(prev_r[slot]);
  assign sum  = {half[SAMPLE_W-1], half} + {prev[SAMPLE_W-1], prev};

  always_comb begin
    if (sum > Q_ONE) begin
      clamped = Q_ONE;
    end else if (sum < -Q_ONE) begin
      clamped = -Q_ONE;
    end else begin
      clamped = sum;
    end
  end

  always_comb begin
    q_item.smp       = nr_on ? clamped[SAMPLE_W-1:0] : in_item.sample_in;
    q_item.fmt       = fmt;
    q_item.block_end = in_item.block_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (q_push && nr_on) begin
      prev_r[slot] <= half;
    end
  end

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !nr_on) |=> $stable(prev_r))
    else $error("channel history changed while smoothing is off");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && nr_on) |-> ($signed(q_item.smp) <= $signed(Q_ONE[SAMPLE_W-1:0]) &&
                           $signed(q_item.smp) >= -$signed(Q_ONE[SAMPLE_W-1:0])))
    else $error("smoothed sample outside the clamp range");

endmodule

// File: rtl/asfc_queue.sv
// Short queue that decouples the front part from the conversion back part.
module asfc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  asfc_pkg::asfc_mid_t   wr_item,
  input  logic                  pop,
  output asfc_pkg::asfc_mid_t   rd_item,
  output asfc_pkg::asfc_qstat_t stat
);
  import asfc_pkg::*;

  asfc_mid_t            mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r;
  logic [MID_PTR_W-1:0] rd_ptr_r;
  logic [MID_PTR_W:0]   cnt_r;
  logic [MID_PTR_W:0]   cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (cnt_r == (MID_PTR_W+1)'(MID_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (MID_PTR_W+1)'(MID_DEPTH))
    else $error("queue fill count beyond its depth");

endmodule

// File: rtl/asfc_back.sv
// Back part: two-stage format conversion feeding the result queue.
module asfc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  asfc_pkg::asfc_qstat_t q_stat,
  input  asfc_pkg::asfc_mid_t   q_item,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output asfc_pkg::asfc_out_t   out_item
);
  import asfc_pkg::*;

  localparam logic signed [33:0] S16_HI = 34'sd32767;
  localparam logic signed [33:0] S16_LO = -34'sd32768;
  localparam logic signed [33:0] S24_HI = 34'sd8388607;
  localparam logic signed [33:0] S24_LO = -34'sd8388608;
  localparam logic signed [33:0] S32_HI = 34'sd2147483647;
  localparam logic signed [33:0] S32_LO = -34'sd2147483648;
  localparam logic signed [33:0] S8_HI  = 34'sd127;
  localparam logic signed [33:0] S8_LO  = -34'sd128;
  localparam logic signed [33:0] U8_OFS = 34'sd127;
  localparam logic signed [33:0] U8_HI  = 34'sd255;
  localparam logic signed [33:0] U8_LO  = 34'sd0;

  function automatic logic [4:0] msb_of(input logic [SAMPLE_W-1:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 1; i < SAMPLE_W; i++) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic logic signed [33:0] sat_val(input logic signed [33:0] v,
                                                 input logic signed [33:0] lo,
                                                 input logic signed [33:0] hi);
    logic signed [33:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Stage A: magnitude, leading one and scaled product.
  logic                       a_v_r;
  logic                       a_neg_r;
  logic [SAMPLE_W-1:0]        a_mag_r;
  logic [4:0]                 a_msb_r;
  logic [62:0]                a_prod_r;
  logic signed [SAMPLE_W-1:0] a_smp_r;
  asfc_fmt_t                  a_fmt_r;
  logic                       a_be_r;

  logic                       in_neg;
  logic [SAMPLE_W-1:0]        in_mag;

  // Result queue.
  asfc_out_t            oq_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_ptr_r;
  logic [OUT_PTR_W-1:0] ord_ptr_r;
  logic [OUT_PTR_W:0]   ocnt_r;
  logic [OUT_PTR_W:0]   ocnt_nxt;
  logic [OUT_PTR_W+1:0] used;
  logic                 do_opop;

  // An item leaves the queue only when the result queue has a place kept for it.
  assign used  = (OUT_PTR_W+2)'(ocnt_r) + (OUT_PTR_W+2)'(a_v_r);
  assign q_pop = !q_stat.empty && (used < (OUT_PTR_W+2)'(OUT_DEPTH));

  assign in_neg = q_item.smp[SAMPLE_W-1];
  assign in_mag = in_neg ? (SAMPLE_W)'(-q_item.smp) : q_item.smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_neg_r  <= in_neg;
      a_mag_r  <= in_mag;
      a_msb_r  <= msb_of(in_mag);
      a_prod_r <= {31'b0, in_mag} * {32'b0, scale_of(q_item.fmt)};
      a_smp_r  <= q_item.smp;
      a_fmt_r  <= q_item.fmt;
      a_be_r   <= q_item.block_end;
    end
  end

  // Stage B: rounding, saturation and packing.
  logic [SAMPLE_W-1:0]   mnorm;
  logic [23:0]           mant24;
  logic                  rnd_up;
  logic [24:0]           mant25;
  logic [31:0]           f32_word;
  logic [63:0]           f64_word;
  logic                  round_fmt;
  logic [62:0]           prod_rnd;
  logic [32:0]           qmag;
  logic signed [33:0]    ival;
  logic [63:0]           s64_word;
  logic signed [33:0]    sat_r16;
  logic signed [33:0]    sat_r24;
  logic signed [33:0]    sat_r32;
  logic signed [33:0]    sat_u8;
  logic signed [33:0]    sat_s8;
  logic [WORD_W-1:0]     word;
  asfc_out_t             b_item;

  assign mnorm  = a_mag_r << (5'd31 - a_msb_r);
  assign mant24 = mnorm[31:8];
  assign rnd_up = mnorm[7] && ((|mnorm[6:0]) || mnorm[8]);
  assign mant25 = {1'b0, mant24} + 25'(rnd_up);

  // The hidden bit of the mantissa carries into the exponent field.
  always_comb begin
    if (a_mag_r == '0) begin
      f32_word = '0;
      f64_word = '0;
    end else begin
      f32_word = {a_neg_r, 31'b0} |
                 ({1'b0, 8'(a_msb_r) + 8'd96, 23'b0} + {7'b0, mant25});
      f64_word = {a_neg_r, 63'b0} |
                 ({1'b0, 11'(a_msb_r) + 11'd992, 52'b0} + {11'b0, mnorm, 21'b0});
    end
  end

  always_comb begin
    case (a_fmt_r)
      FMT_S16, FMT_S24, FMT_U8: round_fmt = 1'b1;
      default:                  round_fmt = 1'b0;
    endcase
  end

  assign prod_rnd = a_prod_r + (round_fmt ? 63'd536870912 : 63'd0);
  assign qmag     = prod_rnd[62:30];
  assign ival     = a_neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  assign sat_r16 = sat_val(ival, S16_LO, S16_HI);
  assign sat_r24 = sat_val(ival, S24_LO, S24_HI);
  assign sat_r32 = sat_val(ival, S32_LO, S32_HI);
  assign sat_u8  = sat_val(ival + U8_OFS, U8_LO, U8_HI);
  assign sat_s8  = sat_val(ival, S8_LO, S8_HI);

  always_comb begin
    if ($signed({a_smp_r[SAMPLE_W-1], a_smp_r}) >= Q_ONE) begin
      s64_word = {1'b0, {63{1'b1}}};
    end else if ($signed({a_smp_r[SAMPLE_W-1], a_smp_r}) <= -Q_ONE) begin
      s64_word = {1'b1, 63'b0};
    end else begin
      s64_word = {a_smp_r, 32'b0} << 1;
    end
  end

  always_comb begin
    word = '0;
    unique case (a_fmt_r)
      FMT_F32: word = {32'b0, f32_word};
      FMT_S16: word = {48'b0, sat_r16[15:0]};
      FMT_S32: word = {32'b0, sat_r32[31:0]};
      FMT_S24: word = {40'b0, sat_r24[23:0]};
      FMT_F64: word = f64_word;
      FMT_S64: word = s64_word;
      FMT_U8:  word = {56'b0, sat_u8[7:0]};
      FMT_S8:  word = {56'b0, sat_s8[7:0]};
      default: word = '0;
    endcase
  end

  always_comb begin
    b_item.out_word      = word;
    b_item.out_bytes     = bytes_of(a_fmt_r);
    b_item.block_end_out = a_be_r;
  end

  assign out_empty = (ocnt_r == '0);
  assign do_opop   = out_pop && !out_empty;
  assign out_item  = oq_r[ord_ptr_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (a_v_r && !do_opop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (do_opop && !a_v_r) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (a_v_r) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (do_opop) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r) begin
      oq_r[owr_ptr_r] <= b_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (OUT_PTR_W+2)'(OUT_DEPTH))
    else $error("result queue and stage A hold more than the queue depth");

  a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> a_v_r ##1 !out_empty)
    else $error("converted sample did not reach the result queue");

endmodule

// File: rtl/audio_sample_format_converter_core.sv
// Top level of the audio sample format converter: configuration registers and the three parts.
// Path: a transferred sample passes the queue, the stage A registers and the result queue to reach the result ports.
// Throughput: one sample per cycle; the two-entry queue and the four-entry result queue
// absorb stalls, and the credit check against the result queue sets the pace under back-pressure.
// Reset (synchronous, rst_n low): queues empty, smoothing off, format s16, channel history zero.
module audio_sample_format_converter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  asfc_pkg::asfc_in_t                   in_data,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output asfc_pkg::asfc_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [asfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asfc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import asfc_pkg::*;

  logic        nr_on_r;
  asfc_fmt_t   fmt_r;
  logic        q_push;
  logic        q_pop;
  asfc_mid_t   q_wr_item;
  asfc_mid_t   q_rd_item;
  asfc_qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_on_r <= 1'b0;
      fmt_r   <= FMT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NR_ON:   nr_on_r <= cfg_wdata[0];
        CFG_OUT_FMT: fmt_r   <= asfc_fmt_t'(cfg_wdata);
        default:     ;
      endcase
    end
  end

  assign in_full = q_stat.full;

  asfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .nr_on   (nr_on_r),
    .fmt     (fmt_r),
    .in_push (in_push),
    .in_item (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  asfc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .stat    (q_stat)
  );

  asfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_data)
  );

endmodule
